/* design/bfpd_pkg.sv */
// Shared types, codes and constants of the bracket framed packet deframer.
package bfpd_pkg;

    localparam logic [7:0] SYNC_CHAR  = 8'h5B;
    localparam logic [7:0] TRAIL_CHAR = 8'h5D;
    localparam int unsigned HDR_BYTES = 8;
    localparam int unsigned HDR_IDX_W = $clog2(HDR_BYTES);
    localparam logic [7:0] MAX_LEN_RESET = 8'd255;

    localparam logic [1:0] KIND_HEADER   = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD  = 2'd1;
    localparam logic [1:0] KIND_COMPLETE = 2'd2;
    localparam logic [1:0] KIND_ERROR    = 2'd3;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_LENGTH  = 2'd1;
    localparam logic [1:0] ERR_TRAILER = 2'd2;

    localparam logic CMD_PARSE = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT0   = 3'd0,
        PH_HUNT1   = 3'd1,
        PH_HEADER  = 3'd2,
        PH_DATA    = 3'd3,
        PH_TRAILER = 3'd4
    } phase_t;

    typedef struct packed {
        logic       command;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  error_code;
        logic [7:0]  frame_id;
        logic [7:0]  frame_length;
        logic [31:0] frame_timestamp;
        logic [15:0] wire_checksum;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic [31:0] bad_frames;
    } out_item_t;

endpackage

/* design/bfpd_parser.sv */
// Frame parsing state machine, header store and bad frame counter.
module bfpd_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  bfpd_pkg::in_item_t  item,
    input  logic [7:0]          max_len,
    output logic                has_result,
    output bfpd_pkg::out_item_t result
);
    import bfpd_pkg::*;

    phase_t phase_reg, phase_next;
    logic [HDR_IDX_W-1:0] hdr_cnt_reg, hdr_cnt_next;
    logic [7:0] hdr_store_reg [HDR_BYTES];
    logic [7:0] data_cnt_reg, data_cnt_next;
    logic trail_seen_reg, trail_seen_next;
    logic [31:0] bad_cnt_reg, bad_cnt_next;

    logic [7:0] hdr_view [HDR_BYTES];
    logic [7:0] c;
    logic is_clear, is_sync, is_trail, hdr_done, len_bad, data_last;
    logic [7:0] data_cnt_inc;

    assign c            = item.rx_byte;
    assign is_clear     = (item.command == CMD_CLEAR);
    assign is_sync      = (c == SYNC_CHAR);
    assign is_trail     = (c == TRAIL_CHAR);
    assign hdr_done     = (hdr_cnt_reg == HDR_IDX_W'(HDR_BYTES - 1));
    assign len_bad      = (hdr_store_reg[1] > max_len);
    assign data_cnt_inc = data_cnt_reg + 8'd1;
    assign data_last    = (data_cnt_inc == hdr_store_reg[1]);

    // The byte being stored this step is visible in the header fields at once.
    always_comb begin
        for (int i = 0; i < HDR_BYTES; i++) begin
            hdr_view[i] = (phase_reg == PH_HEADER && hdr_cnt_reg == HDR_IDX_W'(i))
                          ? c : hdr_store_reg[i];
        end
    end

    // Next phase.
    always_comb begin
        phase_next = phase_reg;
        if (step && !is_clear) begin
            unique case (phase_reg)
                PH_HUNT1:   phase_next = is_sync ? PH_HEADER : PH_HUNT0;
                PH_HEADER: begin
                    if (hdr_done) begin
                        if (len_bad) begin
                            phase_next = PH_HUNT0;
                        end else if (hdr_store_reg[1] == 8'd0) begin
                            phase_next = PH_TRAILER;
                        end else begin
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_DATA:    phase_next = data_last ? PH_TRAILER : PH_DATA;
                PH_TRAILER: phase_next = (is_trail && !trail_seen_reg) ? PH_TRAILER : PH_HUNT0;
                default:    phase_next = is_sync ? PH_HUNT1 : PH_HUNT0;
            endcase
        end
    end

    // Result and the remaining state.
    always_comb begin
        hdr_cnt_next           = hdr_cnt_reg;
        data_cnt_next          = data_cnt_reg;
        trail_seen_next        = trail_seen_reg;
        bad_cnt_next           = bad_cnt_reg;
        has_result             = 1'b0;
        result.kind            = KIND_HEADER;
        result.error_code      = ERR_NONE;
        result.frame_id        = hdr_view[0];
        result.frame_length    = hdr_view[1];
        result.frame_timestamp = {hdr_view[5], hdr_view[4], hdr_view[3], hdr_view[2]};
        result.wire_checksum   = {hdr_view[7], hdr_view[6]};
        result.payload_byte    = 8'd0;
        result.payload_index   = 8'd0;
        if (step) begin
            if (is_clear) begin
                bad_cnt_next = 32'd0;
            end else begin
                unique case (phase_reg)
                    PH_HUNT1: begin
                        if (is_sync) begin
                            hdr_cnt_next = '0;
                        end
                    end
                    PH_HEADER: begin
                        hdr_cnt_next = hdr_cnt_reg + 1'b1;
                        if (hdr_done) begin
                            has_result   = 1'b1;
                            hdr_cnt_next = '0;
                            if (len_bad) begin
                                bad_cnt_next      = bad_cnt_reg + 32'd1;
                                result.kind       = KIND_ERROR;
                                result.error_code = ERR_LENGTH;
                            end else begin
                                data_cnt_next   = 8'd0;
                                trail_seen_next = 1'b0;
                            end
                        end
                    end
                    PH_DATA: begin
                        has_result           = 1'b1;
                        result.kind          = KIND_PAYLOAD;
                        result.payload_byte  = c;
                        result.payload_index = data_cnt_reg;
                        data_cnt_next        = data_cnt_inc;
                        if (data_last) begin
                            trail_seen_next = 1'b0;
                        end
                    end
                    PH_TRAILER: begin
                        if (!is_trail) begin
                            has_result        = 1'b1;
                            bad_cnt_next      = bad_cnt_reg + 32'd1;
                            trail_seen_next   = 1'b0;
                            result.kind       = KIND_ERROR;
                            result.error_code = ERR_TRAILER;
                        end else if (!trail_seen_reg) begin
                            trail_seen_next = 1'b1;
                        end else begin
                            has_result      = 1'b1;
                            trail_seen_next = 1'b0;
                            result.kind     = KIND_COMPLETE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
        result.bad_frames = bad_cnt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HUNT0;
            hdr_cnt_reg    <= '0;
            data_cnt_reg   <= 8'd0;
            trail_seen_reg <= 1'b0;
            bad_cnt_reg    <= 32'd0;
        end else begin
            phase_reg      <= phase_next;
            hdr_cnt_reg    <= hdr_cnt_next;
            data_cnt_reg   <= data_cnt_next;
            trail_seen_reg <= trail_seen_next;
            bad_cnt_reg    <= bad_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && !is_clear && phase_reg == PH_HEADER) begin
            hdr_store_reg[hdr_cnt_reg] <= c;
        end
    end

`ifndef SYNTH
    a_error_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (has_result && result.kind == KIND_ERROR)
        |=> (bad_cnt_reg == $past(bad_cnt_reg) + 32'd1))
        else $error("frame error did not count a bad frame");

    a_clear_zeroes: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && is_clear) |=> (bad_cnt_reg == 32'd0))
        else $error("clear command did not zero the bad frame count");

    a_data_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DATA) |-> (data_cnt_reg < hdr_store_reg[1]))
        else $error("payload index ran past the frame length");
`endif

endmodule

/* design/bfpd_result_reg.sv */
// Result register that holds one item for the output channel.
module bfpd_result_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  bfpd_pkg::out_item_t load_data,
    output logic                can_load,
    output logic                m_valid,
    input  logic                m_ready,
    output bfpd_pkg::out_item_t m_data
);
    import bfpd_pkg::*;

    logic      valid_reg, valid_next;
    out_item_t data_reg;

    assign can_load = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

/* design/bracket_framed_packet_deframer_unit.sv */
// Top level of the bracket framed packet deframer.
// The deframer takes one item per clock: a received byte to parse or a command that
// clears the bad frame count. It hunts for the sync pair "[[", gathers an eight byte
// header (id, length, little endian 32-bit timestamp, 16-bit checksum low byte first),
// passes on the payload bytes one at a time with their index and then checks the
// trailer "]]". Each item yields at most one result: header accepted, payload
// byte, frame complete or frame error (length above max_payload_length, or a bad
// trailer byte). Every result carries the header fields of the current frame and the
// bad frame count after the item. The checksum is not verified here; the wire value
// is handed on for downstream logic. An item passes through an input register and a
// result register: it is parsed from the input register once the result register can
// take a result, and any result is then registered and shown on m_valid. One item
// can be accepted in every cycle as long as the output side takes results; while a
// result waits in the result register, the held item cannot move on
// and s_ready drops. There is no clearing pass after reset; the block accepts items
// in the first cycle after it. The cfg port writes max_payload_length (reset 255) and
// is always ready; it should only be written while no item is in flight.
module bracket_framed_packet_deframer_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bfpd_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output bfpd_pkg::out_item_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_data
);
    import bfpd_pkg::*;

    // Input register: the item is held here while it is parsed and until it can move on.
    logic      in_valid_reg, in_valid_next;
    in_item_t  in_item_reg;
    logic      advance;
    logic [7:0] max_len_reg;

    logic      has_result;
    out_item_t result;
    logic      res_load;
    logic      res_can_load;

    // The held item moves on whenever the result register can take its result,
    // which frees the input register for a new item in the same cycle.
    assign advance   = in_valid_reg && res_can_load;
    assign s_ready   = !in_valid_reg || advance;
    assign res_load  = advance && has_result;
    assign cfg_ready = 1'b1;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            max_len_reg  <= MAX_LEN_RESET;
        end else begin
            in_valid_reg <= in_valid_next;
            if (cfg_valid && cfg_ready) begin
                max_len_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    bfpd_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .item       (in_item_reg),
        .max_len    (max_len_reg),
        .has_result (has_result),
        .result     (result)
    );

    bfpd_result_reg u_result_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (res_load),
        .load_data (result),
        .can_load  (res_can_load),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

`ifndef SYNTH
    // A held item that cannot move on must stay in the input register untouched.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("stalled input item was lost or changed");

    // A result is only loaded when the output side has room for it.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !res_load)
        else $error("result register overwritten while waiting");

    // A waiting result item stays on the output unchanged until it is taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("waiting result item was dropped or changed");
`endif

endmodule
